[rtl/pvl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the planar velocity limiter.
// No dependencies.
package pvl_pkg;

    localparam int SQRT_STAGES = 16;
    localparam int DIV_STAGES  = 16;
    localparam int SB_STAGES   = SQRT_STAGES + DIV_STAGES;

    typedef enum logic [1:0] {
        CFG_MOTION_ENABLED    = 2'd0,
        CFG_MAX_TRANSLATIONAL = 2'd1,
        CFG_MAX_ROTATIONAL    = 2'd2,
        CFG_DEAD_BAND         = 2'd3
    } pvl_cfg_idx_t;

    // Per-transaction fields riding alongside the sqrt and divide pipes.
    typedef struct packed {
        logic               sx;
        logic               sy;
        logic [15:0]        ax;
        logic [15:0]        ay;
        logic [29:0]        nx;
        logic [29:0]        ny;
        logic               scale;
        logic signed [15:0] dh;
    } pvl_sb_t;

endpackage

[rtl/pvl_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on pvl_pkg.
module pvl_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] rad_in,
    output logic [15:0] root_out
);
    import pvl_pkg::*;

    logic [16:0] rem_reg  [SQRT_STAGES];
    logic [15:0] root_reg [SQRT_STAGES];
    logic [31:0] rad_reg  [SQRT_STAGES];
    logic [16:0] rem_next  [SQRT_STAGES];
    logic [15:0] root_next [SQRT_STAGES];
    logic [31:0] rad_next  [SQRT_STAGES];

    always_comb begin
        logic [16:0] rem_in;
        logic [15:0] root_in;
        logic [31:0] rad_i;
        logic [18:0] rem_sh;
        logic [18:0] trial;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            rem_in  = (k == 0) ? 17'd0 : rem_reg[(k == 0) ? 0 : k - 1];
            root_in = (k == 0) ? 16'd0 : root_reg[(k == 0) ? 0 : k - 1];
            rad_i   = (k == 0) ? rad_in : rad_reg[(k == 0) ? 0 : k - 1];
            rem_sh  = {rem_in[16:0], rad_i[31:30]};
            trial   = {1'b0, root_in, 2'b01};
            if (rem_sh >= trial) begin
                rem_next[k]  = 17'(rem_sh - trial);
                root_next[k] = {root_in[14:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh[16:0];
                root_next[k] = {root_in[14:0], 1'b0};
            end
            rad_next[k] = {rad_i[29:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign root_out = root_reg[SQRT_STAGES-1];

endmodule

[rtl/pvl_div.sv]
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider sharing one divisor; 16-bit quotients.
// Depends on pvl_pkg. Needs quotient < 2^16.
module pvl_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [29:0] nx_in,
    input  logic [29:0] ny_in,
    input  logic [15:0] d_in,
    output logic [15:0] qx_out,
    output logic [15:0] qy_out
);
    import pvl_pkg::*;

    logic [15:0] d_reg  [DIV_STAGES];
    logic [15:0] rem_reg  [DIV_STAGES][2];
    logic [15:0] low_reg  [DIV_STAGES][2];
    logic [15:0] q_reg    [DIV_STAGES][2];
    logic [15:0] rem_next [DIV_STAGES][2];
    logic [15:0] low_next [DIV_STAGES][2];
    logic [15:0] q_next   [DIV_STAGES][2];

    always_comb begin
        logic [15:0] d_i;
        logic [15:0] rem_in;
        logic [15:0] low_in;
        logic [15:0] q_in;
        logic [29:0] n_i;
        logic [16:0] t;
        for (int k = 0; k < DIV_STAGES; k++) begin
            for (int l = 0; l < 2; l++) begin
                n_i    = (l == 0) ? nx_in : ny_in;
                d_i    = (k == 0) ? d_in : d_reg[(k == 0) ? 0 : k - 1];
                rem_in = (k == 0) ? {2'b00, n_i[29:16]}
                                  : rem_reg[(k == 0) ? 0 : k - 1][l];
                low_in = (k == 0) ? n_i[15:0] : low_reg[(k == 0) ? 0 : k - 1][l];
                q_in   = (k == 0) ? 16'd0 : q_reg[(k == 0) ? 0 : k - 1][l];
                t      = {rem_in, low_in[15]};
                if (t >= {1'b0, d_i}) begin
                    rem_next[k][l] = 16'(t - {1'b0, d_i});
                    q_next[k][l]   = {q_in[14:0], 1'b1};
                end else begin
                    rem_next[k][l] = t[15:0];
                    q_next[k][l]   = {q_in[14:0], 1'b0};
                end
                low_next[k][l] = {low_in[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                d_reg[k] <= (k == 0) ? d_in : d_reg[(k == 0) ? 0 : k - 1];
                for (int l = 0; l < 2; l++) begin
                    rem_reg[k][l] <= rem_next[k][l];
                    low_reg[k][l] <= low_next[k][l];
                    q_reg[k][l]   <= q_next[k][l];
                end
            end
        end
    end

    assign qx_out = q_reg[DIV_STAGES-1][0];
    assign qy_out = q_reg[DIV_STAGES-1][1];

endmodule

[rtl/planar_velocity_limiter_core.sv]
`timescale 1ns / 1ps
// Planar velocity limiter top: difference, magnitude clamp, heading clamp, dead band.
// Pipeline: 4 front stages, 16 sqrt, 16 divide, 1 output register.
// Throughput: one transaction per cycle; the whole pipe advances unless the output
// register holds an untaken result. Disabled motion drops the transaction at entry.
// Reset (aresetn low, synchronous) clears all valid bits and loads register defaults.
// Depends on pvl_pkg, pvl_sqrt, pvl_div.
module planar_velocity_limiter_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_desired_x,
    input  logic signed [15:0] s_desired_y,
    input  logic signed [15:0] s_desired_heading,
    input  logic signed [15:0] s_actual_x,
    input  logic signed [15:0] s_actual_y,
    input  logic signed [15:0] s_actual_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_linear_x,
    output logic signed [15:0] m_linear_y,
    output logic signed [15:0] m_angular_z,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data
);
    import pvl_pkg::*;

    // ---------------- configuration registers ----------------
    logic        motion_enabled_reg;
    logic [14:0] max_trans_reg;
    logic [14:0] max_rot_reg;
    logic [14:0] dead_band_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motion_enabled_reg <= 1'b0;
            max_trans_reg      <= 15'd256;
            max_rot_reg        <= 15'd256;
            dead_band_reg      <= 15'd3;
        end else if (cfg_we) begin
            case (pvl_cfg_idx_t'(cfg_index))
                CFG_MOTION_ENABLED:    motion_enabled_reg <= cfg_data[0];
                CFG_MAX_TRANSLATIONAL: max_trans_reg      <= cfg_data;
                CFG_MAX_ROTATIONAL:    max_rot_reg        <= cfg_data;
                CFG_DEAD_BAND:         dead_band_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: everything moves when the output slot is free or being taken.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: saturated differences ----------------
    logic               v1_reg;
    logic signed [15:0] dx1_reg, dy1_reg, dh1_reg;

    function automatic logic signed [15:0] sat_diff(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
        logic signed [16:0] d;
        d = 17'(a) - 17'(b);
        if (d > 17'sd32767)       sat_diff = 16'sh7fff;
        else if (d < -17'sd32768) sat_diff = 16'sh8000;
        else                      sat_diff = d[15:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_valid && motion_enabled_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg <= sat_diff(s_desired_x, s_actual_x);
            dy1_reg <= sat_diff(s_desired_y, s_actual_y);
            dh1_reg <= sat_diff(s_desired_heading, s_actual_heading);
        end
    end

    // ---------------- stage 2: magnitudes, signs, heading clamp ----------------
    logic               v2_reg;
    logic               sx2_reg, sy2_reg;
    logic [15:0]        ax2_reg, ay2_reg;
    logic signed [15:0] dh2_reg;
    logic signed [15:0] dh2_next;
    logic signed [16:0] mr;

    always_comb begin
        mr = {2'b00, max_rot_reg};
        if (17'(dh1_reg) > mr)       dh2_next = mr[15:0];
        else if (17'(dh1_reg) < -mr) dh2_next = 16'(-mr);
        else                         dh2_next = dh1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sx2_reg <= dx1_reg[15];
            sy2_reg <= dy1_reg[15];
            ax2_reg <= dx1_reg[15] ? 16'(-dx1_reg) : dx1_reg;
            ay2_reg <= dy1_reg[15] ? 16'(-dy1_reg) : dy1_reg;
            dh2_reg <= dh2_next;
        end
    end

    // ---------------- stage 3: squares and scaled numerators ----------------
    logic               v3_reg;
    logic               sx3_reg, sy3_reg;
    logic [15:0]        ax3_reg, ay3_reg;
    logic signed [15:0] dh3_reg;
    logic [31:0]        sqx3_reg, sqy3_reg;
    logic [29:0]        lim2_reg;
    logic [29:0]        nx3_reg, ny3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            dh3_reg  <= dh2_reg;
            sqx3_reg <= ax2_reg * ax2_reg;
            sqy3_reg <= ay2_reg * ay2_reg;
            nx3_reg  <= 30'(ax2_reg * max_trans_reg);
            ny3_reg  <= 30'(ay2_reg * max_trans_reg);
            lim2_reg <= max_trans_reg * max_trans_reg;
        end
    end

    // ---------------- stage 4: magnitude squared and over-limit test ----------------
    logic        v4_reg;
    pvl_sb_t     sb4_reg;
    logic [31:0] mag2_reg;
    logic [31:0] mag2_next;

    assign mag2_next = sqx3_reg + sqy3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            mag2_reg      <= mag2_next;
            sb4_reg.sx    <= sx3_reg;
            sb4_reg.sy    <= sy3_reg;
            sb4_reg.ax    <= ax3_reg;
            sb4_reg.ay    <= ay3_reg;
            sb4_reg.nx    <= nx3_reg;
            sb4_reg.ny    <= ny3_reg;
            sb4_reg.dh    <= dh3_reg;
            sb4_reg.scale <= mag2_next > {2'b00, lim2_reg};
        end
    end

    // ---------------- sqrt and divide, sideband delay line alongside ----------------
    // root >= max_translational whenever scaling applies, so quotients fit 16 bits.
    logic [15:0]     root;
    logic [15:0]     qx, qy;
    pvl_sb_t         sb_reg [SB_STAGES];
    logic [SB_STAGES-1:0] sb_vld_reg;

    pvl_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .rad_in   (mag2_reg),
        .root_out (root)
    );

    pvl_div u_div (
        .aclk   (aclk),
        .en     (en),
        .nx_in  (sb_reg[SQRT_STAGES-1].nx),
        .ny_in  (sb_reg[SQRT_STAGES-1].ny),
        .d_in   (root),
        .qx_out (qx),
        .qy_out (qy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) sb_vld_reg <= '0;
        else if (en)  sb_vld_reg <= {sb_vld_reg[SB_STAGES-2:0], v4_reg};
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= sb4_reg;
            for (int k = 1; k < SB_STAGES; k++) sb_reg[k] <= sb_reg[k-1];
        end
    end

    // ---------------- output: select scaled value, dead band, sign ----------------
    pvl_sb_t     sbo;
    logic [15:0] mx, my, mh;
    logic [15:0] ox, oy, oh;

    always_comb begin
        sbo = sb_reg[SB_STAGES-1];
        mx  = sbo.scale ? qx : sbo.ax;
        my  = sbo.scale ? qy : sbo.ay;
        mh  = sbo.dh[15] ? 16'(-sbo.dh) : sbo.dh;
        ox  = (mx < {1'b0, dead_band_reg}) ? 16'd0 : (sbo.sx ? 16'(-mx) : mx);
        oy  = (my < {1'b0, dead_band_reg}) ? 16'd0 : (sbo.sy ? 16'(-my) : my);
        oh  = (mh < {1'b0, dead_band_reg}) ? 16'd0 : sbo.dh;
    end

    logic               m_valid_reg;
    logic signed [15:0] lx_reg, ly_reg, az_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en)  m_valid_reg <= sb_vld_reg[SB_STAGES-1];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            lx_reg <= ox;
            ly_reg <= oy;
            az_reg <= oh;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_linear_x  = lx_reg;
    assign m_linear_y  = ly_reg;
    assign m_angular_z = az_reg;

    // ---------------- assertions ----------------
    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(sb_vld_reg))
        else $error("pipe valid bits moved during stall");

    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> m_valid_reg == $past(sb_vld_reg[SB_STAGES-1]))
        else $error("output valid not loaded from last pipe stage");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && sb_vld_reg == '0 && !v1_reg)
        else $error("valid bits not cleared by reset");

endmodule

[verif/planar_velocity_limiter_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for planar_velocity_limiter_core: difference, magnitude clamp,
// heading clamp and dead band, checked against an internal predictor per transaction.
// Depends on pvl_pkg and the RTL of the limiter core.
module planar_velocity_limiter_core_tb;
    import pvl_pkg::*;

    localparam int LATENCY   = 37;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] az;
    } cmd_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_desired_x = '0, s_desired_y = '0, s_desired_heading = '0;
    logic signed [15:0] s_actual_x = '0, s_actual_y = '0, s_actual_heading = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_linear_x, m_linear_y, m_angular_z;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [14:0]        cfg_data = '0;

    // Predictor's copy of the registers.
    logic        en_q;
    logic [14:0] vmax_q, wmax_q, band_q;

    cmd_t expected_cmds[$];
    int   mismatches = 0;
    int   unexpected = 0;
    int   sent = 0;
    int   received = 0;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    planar_velocity_limiter_core DUT (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a run that reaches the cycle cap is a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] sat_diff(logic signed [15:0] a, logic signed [15:0] b);
        logic signed [17:0] d;
        d = 18'(a) - 18'(b);
        if (d > 18'sd32767) return 16'sh7fff;
        if (d < -18'sd32768) return 16'sh8000;
        return d[15:0];
    endfunction

    function automatic logic [15:0] floor_root(logic [31:0] v);
        logic [15:0] r;
        logic [15:0] t;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (16'd1 << b);
            if (32'(t) * 32'(t) <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] apply_band(logic signed [31:0] v);
        logic signed [31:0] m;
        m = (v < 0) ? -v : v;
        return (m < $signed({17'd0, band_q})) ? 16'sd0 : v[15:0];
    endfunction

    // Expected command for one transaction at the current register settings.
    function automatic cmd_t limit_velocity(logic signed [15:0] dxs, logic signed [15:0] dys,
                                            logic signed [15:0] dhs, logic signed [15:0] axs,
                                            logic signed [15:0] ays, logic signed [15:0] ahs);
        logic signed [63:0] dx, dy, dh, root, lim;
        logic [63:0]        mag2;
        cmd_t               c;
        dx = sat_diff(dxs, axs);
        dy = sat_diff(dys, ays);
        dh = sat_diff(dhs, ahs);
        lim = {49'd0, vmax_q};
        mag2 = dx * dx + dy * dy;
        if (mag2 > lim * lim) begin
            root = {48'd0, floor_root(mag2[31:0])};
            dx = (dx * lim) / root;   // truncates toward zero
            dy = (dy * lim) / root;
        end
        if (dh > $signed({49'd0, wmax_q})) dh = {49'd0, wmax_q};
        else if (dh < -$signed({49'd0, wmax_q})) dh = -$signed({49'd0, wmax_q});
        c.lx = apply_band(dx[31:0]);
        c.ly = apply_band(dy[31:0]);
        c.az = apply_band(dh[31:0]);
        return c;
    endfunction

    // Result checker and receiver back-pressure.
    always @(posedge aclk) begin
        cmd_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            received++;
            if (expected_cmds.size() == 0) begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected command %0d %0d %0d", m_linear_x, m_linear_y, m_angular_z);
            end else begin
                exp_c = expected_cmds.pop_front();
                if (exp_c.lx !== m_linear_x || exp_c.ly !== m_linear_y
                        || exp_c.az !== m_angular_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 exp_c.lx, exp_c.ly, exp_c.az,
                                 m_linear_x, m_linear_y, m_angular_z);
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(pvl_cfg_idx_t idx, logic [14:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MOTION_ENABLED:    en_q = val[0];
            CFG_MAX_TRANSLATIONAL: vmax_q = val;
            CFG_MAX_ROTATIONAL:    wmax_q = val;
            CFG_DEAD_BAND:         band_q = val;
            default: ;
        endcase
    endtask

    task automatic setup(logic en, logic [14:0] vmax, logic [14:0] wmax, logic [14:0] band);
        write_reg(CFG_MOTION_ENABLED, {14'd0, en});
        write_reg(CFG_MAX_TRANSLATIONAL, vmax);
        write_reg(CFG_MAX_ROTATIONAL, wmax);
        write_reg(CFG_DEAD_BAND, band);
    endtask

    // One transaction; valid held until accepted. Drives at falling edge and returns
    // at the accepting rising edge; the next call redrives valid (low while idle), drain() takes it down.
    task automatic send_relation(logic signed [15:0] dx, logic signed [15:0] dy,
                                 logic signed [15:0] dh, logic signed [15:0] ax,
                                 logic signed [15:0] ay, logic signed [15:0] ah);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_desired_x <= dx; s_desired_y <= dy; s_desired_heading <= dh;
        s_actual_x <= ax;  s_actual_y <= ay;  s_actual_heading <= ah;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (en_q) expected_cmds.push_back(limit_velocity(dx, dy, dh, ax, ay, ah));
        sent++;
    endtask

    // Wait for outstanding commands, then cover the latency before touching registers.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(int n, int span);
        logic signed [15:0] base;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                send_relation(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom));
            else begin
                // Mostly small errors around a common base so clamps and dead band both bite.
                base = 16'($urandom);
                send_relation(base + 16'($urandom_range(2 * span) - span),
                              base + 16'($urandom_range(2 * span) - span),
                              base + 16'($urandom_range(2 * span) - span),
                              base, base, base);
            end
        end
    endtask

    task automatic test_directed();
        setup(1'b1, 15'd256, 15'd256, 15'd3);
        send_relation(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
        send_relation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_relation(16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0);   // at limit
        send_relation(16'sd257, 16'sd0, 16'sd257, 16'sd0, 16'sd0, 16'sd0);
        send_relation(16'sd2, -16'sd2, 16'sd3, 16'sd0, 16'sd0, 16'sd0);       // dead band edge
        send_relation(-16'sd3, 16'sd3, -16'sd2, 16'sd0, 16'sd0, 16'sd0);
        send_relation(16'sd300, 16'sd400, -16'sd999, 16'sd0, 16'sd0, 16'sd0);
        send_relation(-16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_relation(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
        drain();
        setup(1'b1, 15'd0, 15'd0, 15'd0);    // zero limits, zero dead band
        send_relation(16'sd1, 16'sd0, 16'sd5, 16'sd0, 16'sd0, 16'sd0);
        send_relation(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_relation(-16'sd700, 16'sd9, -16'sd5, 16'sd0, 16'sd0, 16'sd0);
        drain();
        setup(1'b1, 15'h7fff, 15'h7fff, 15'h7fff);
        send_relation(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd0, 16'sh8000);
        send_relation(16'sh8000, 16'sd1, 16'sh8001, 16'sd0, 16'sd0, 16'sd0);
        drain();
        setup(1'b0, 15'd256, 15'd256, 15'd3); // disabled: nothing comes back
        send_relation(16'sd100, 16'sd100, 16'sd100, 16'sd0, 16'sd0, 16'sd0);
        send_relation(16'sh7fff, 16'sh8000, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
        drain();
    endtask

    task automatic test_random_phases();
        int idle_s[4] = '{0, 56, 0, 7};
        int idle_r[4] = '{0, 0, 56, 7};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_s[p];
            recv_stall_pct = idle_r[p];
            setup(1'b1, 15'($urandom_range(1, 2000)), 15'($urandom_range(1, 2000)),
                  15'($urandom_range(0, 40)));
            send_random(120, 2500);
            drain();
        end
    endtask

    task automatic test_extreme_settings();
        send_idle_pct = 20;
        recv_stall_pct = 20;
        setup(1'b1, 15'h7fff, 15'd0, 15'h7fff);
        send_random(40, 30000);
        drain();
        setup(1'b1, 15'd0, 15'h7fff, 15'd0);
        send_random(40, 30000);
        drain();
        setup(1'b0, 15'd50, 15'd50, 15'd1);
        send_random(20, 3000);
        drain();
        setup(1'b1, 15'd50, 15'd50, 15'd1);
        send_random(60, 3000);
        drain();
    endtask

    initial begin
        en_q = 1'b0; vmax_q = 15'd256; wmax_q = 15'd256; band_q = 15'd3;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_phases();
        test_extreme_settings();
        $display("Sent %0d transactions over several limit settings and idle mixes;", sent);
        $display("checked %0d commands, %0d mismatches.", received, mismatches);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[sim.f]
rtl/pvl_pkg.sv
rtl/pvl_sqrt.sv
rtl/pvl_div.sv
rtl/planar_velocity_limiter_core.sv
verif/planar_velocity_limiter_core_tb.sv
